FILE: sv/tdas_pkg.sv
// shared types and constants for the tiled display area splitter
// no dependencies
package tdas_pkg;

    localparam int MAX_PANELS = 3;
    localparam int COORD_W    = 11;
    localparam int LOCAL_W    = 10;
    localparam int SIZE_W     = 11;
    localparam int START_W    = 22;
    localparam int STRIDE_W   = 12;
    localparam int IDX_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_PANELS_READY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_BASE  = 3'd1;

    // origin reset values per panel
    localparam logic [COORD_W-1:0] ORG_X_RST [MAX_PANELS] = '{11'd0, 11'd240, 11'd480};
    localparam logic [COORD_W-1:0] ORG_Y_RST [MAX_PANELS] = '{11'd0, 11'd0, 11'd0};

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } t_rect;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_origin;

    typedef struct packed {
        logic [LOCAL_W-1:0]  local_x;
        logic [LOCAL_W-1:0]  local_y;
        logic [SIZE_W-1:0]   width;
        logic [SIZE_W-1:0]   height;
        logic [START_W-1:0]  start;
        logic [STRIDE_W-1:0] stride;
        logic                contig;
    } t_window;

endpackage

FILE: sv/tdas_cfg_regs.sv
// configuration register file: panels ready flag and panel origins
// depends on tdas_pkg
module tdas_cfg_regs #(
    parameter int PANEL_COUNT_P = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [tdas_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tdas_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_panels_ready,
    output tdas_pkg::t_origin                  o_origin [PANEL_COUNT_P]
);
    import tdas_pkg::*;

    logic    r_panels_ready;
    t_origin r_origin [PANEL_COUNT_P];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panels_ready <= 1'b0;
        end else if (i_cfg_valid && i_cfg_index == CFG_PANELS_READY) begin
            r_panels_ready <= i_cfg_data[0];
        end
    end

    for (genvar p = 0; p < PANEL_COUNT_P; p++) begin : g_panel
        localparam logic [CFG_IDX_W-1:0] X_IDX = CFG_IDX_W'(CFG_ORIGIN_BASE + 2 * p);
        localparam logic [CFG_IDX_W-1:0] Y_IDX = CFG_IDX_W'(CFG_ORIGIN_BASE + 2 * p + 1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_origin[p].x <= ORG_X_RST[p];
                r_origin[p].y <= ORG_Y_RST[p];
            end else if (i_cfg_valid) begin
                if (i_cfg_index == X_IDX) begin
                    r_origin[p].x <= i_cfg_data;
                end
                if (i_cfg_index == Y_IDX) begin
                    r_origin[p].y <= i_cfg_data;
                end
            end
        end

        assign o_origin[p] = r_origin[p];
    end

    assign o_panels_ready = r_panels_ready;

endmodule

FILE: sv/tdas_clip_lane.sv
// clips one rectangle against one panel and forms its window word
// depends on tdas_pkg
module tdas_clip_lane #(
    parameter int TILE_WIDTH  = 240,
    parameter int TILE_HEIGHT = 240
) (
    input  tdas_pkg::t_rect   i_rect,
    input  tdas_pkg::t_origin i_origin,
    output logic              o_hit,
    output tdas_pkg::t_window o_win
);
    import tdas_pkg::*;

    logic [COORD_W:0]     sx2;
    logic [COORD_W:0]     sy2;
    logic [COORD_W-1:0]   ix1;
    logic [COORD_W-1:0]   iy1;
    logic [COORD_W-1:0]   ix2;
    logic [COORD_W-1:0]   iy2;
    logic [COORD_W-1:0]   dx;
    logic [COORD_W-1:0]   dy;
    logic [STRIDE_W-1:0]  aw;
    logic [SIZE_W-1:0]    w;
    logic [START_W:0]     prod;

    always_comb begin
        sx2 = {1'b0, i_origin.x} + (COORD_W + 1)'(TILE_WIDTH - 1);
        sy2 = {1'b0, i_origin.y} + (COORD_W + 1)'(TILE_HEIGHT - 1);
        ix1 = (i_rect.left > i_origin.x) ? i_rect.left : i_origin.x;
        iy1 = (i_rect.top > i_origin.y) ? i_rect.top : i_origin.y;
        ix2 = ({1'b0, i_rect.right} < sx2) ? i_rect.right : sx2[COORD_W-1:0];
        iy2 = ({1'b0, i_rect.bottom} < sy2) ? i_rect.bottom : sy2[COORD_W-1:0];
        o_hit = (ix1 <= ix2) && (iy1 <= iy2);

        aw   = {1'b0, i_rect.right} - {1'b0, i_rect.left} + STRIDE_W'(1);
        w    = ix2 - ix1 + SIZE_W'(1);
        dx   = ix1 - i_rect.left;
        dy   = iy1 - i_rect.top;
        prod = {12'd0, dy} * {11'd0, aw};

        o_win.local_x = LOCAL_W'(ix1 - i_origin.x);
        o_win.local_y = LOCAL_W'(iy1 - i_origin.y);
        o_win.width   = w;
        o_win.height  = iy2 - iy1 + SIZE_W'(1);
        o_win.start   = prod[START_W-1:0] + START_W'(dx);
        o_win.stride  = aw;
        o_win.contig  = ({1'b0, w} == aw);
    end

endmodule

FILE: sv/tdas_emitter.sv
// window buffer: holds the clipped windows of one rectangle and sends them out
// one word per cycle in panel order while i_ready is high; depends on tdas_pkg
module tdas_emitter #(
    parameter int PANEL_COUNT_P = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    output logic                          o_load_ready,
    input  logic [PANEL_COUNT_P-1:0]      i_hit,
    input  tdas_pkg::t_window             i_win [PANEL_COUNT_P],
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tdas_pkg::IDX_W-1:0]    o_panel_index,
    output logic                          o_last,
    output tdas_pkg::t_window             o_win
);
    import tdas_pkg::*;

    logic [PANEL_COUNT_P-1:0] r_mask;
    logic [PANEL_COUNT_P-1:0] n_mask;
    t_window                  r_win [PANEL_COUNT_P];
    logic [PANEL_COUNT_P-1:0] grant;
    logic [PANEL_COUNT_P-1:0] rest;
    logic                     pop;
    logic                     load;

    always_comb begin
        grant        = r_mask & (~r_mask + PANEL_COUNT_P'(1));
        rest         = r_mask & ~grant;
        o_valid      = |r_mask;
        o_last       = (rest == '0);
        pop          = o_valid && i_ready;
        o_load_ready = !o_valid || (pop && o_last);
        load         = i_load && o_load_ready;

        if (load) begin
            n_mask = i_hit;
        end else if (pop) begin
            n_mask = rest;
        end else begin
            n_mask = r_mask;
        end

        o_win         = '0;
        o_panel_index = '0;
        for (int p = 0; p < PANEL_COUNT_P; p++) begin
            if (grant[p]) begin
                o_win         = t_window'(o_win | r_win[p]);
                o_panel_index = o_panel_index | IDX_W'(p);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int p = 0; p < PANEL_COUNT_P; p++) begin
                r_win[p] <= i_win[p];
            end
        end
    end

endmodule

FILE: sv/tiled_display_area_splitter_unit.sv
// top level of the tiled display area splitter
// depends on tdas_pkg, tdas_cfg_regs, tdas_clip_lane, tdas_emitter
//
// A rectangle word is registered on acceptance; every panel is then clipped in
// parallel from that register and the non-empty windows land in the window
// buffer, from which one window word per cycle leaves in panel order while the
// output is ready, the final one flagged last_window. A rectangle holds the
// window buffer until its last window word is taken, so the single output word
// per cycle sets the rate when several panels are hit; rectangles giving one
// window or none are taken every cycle while the output is ready. A rectangle
// loaded while panels_ready is 0 yields no windows. Configuration writes are
// always accepted and are meant to happen only while the block is idle.
module tiled_display_area_splitter_unit #(
    parameter int PANEL_COUNT_P = 3,
    parameter int TILE_WIDTH    = 240,
    parameter int TILE_HEIGHT   = 240
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tdas_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tdas_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [tdas_pkg::COORD_W-1:0]       i_area_left,
    input  logic [tdas_pkg::COORD_W-1:0]       i_area_top,
    input  logic [tdas_pkg::COORD_W-1:0]       i_area_right,
    input  logic [tdas_pkg::COORD_W-1:0]       i_area_bottom,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tdas_pkg::IDX_W-1:0]         o_panel_index,
    output logic [tdas_pkg::LOCAL_W-1:0]       o_local_x,
    output logic [tdas_pkg::LOCAL_W-1:0]       o_local_y,
    output logic [tdas_pkg::SIZE_W-1:0]        o_window_width,
    output logic [tdas_pkg::SIZE_W-1:0]        o_window_height,
    output logic [tdas_pkg::START_W-1:0]       o_source_start,
    output logic [tdas_pkg::STRIDE_W-1:0]      o_source_stride,
    output logic                               o_rows_contiguous,
    output logic                               o_last_window
);
    import tdas_pkg::*;

    logic                     panels_ready;
    t_origin                  origin [PANEL_COUNT_P];
    t_rect                    r_rect;
    logic                     r_in_vld;
    logic                     load_ready;
    logic [PANEL_COUNT_P-1:0] lane_hit;
    logic [PANEL_COUNT_P-1:0] hit;
    t_window                  lane_win [PANEL_COUNT_P];
    t_window                  out_win;

    assign o_cfg_ready = 1'b1;

    tdas_cfg_regs #(
        .PANEL_COUNT_P(PANEL_COUNT_P)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_panels_ready(panels_ready),
        .o_origin      (origin)
    );

    assign o_in_ready = !r_in_vld || load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_rect.left   <= i_area_left;
            r_rect.top    <= i_area_top;
            r_rect.right  <= i_area_right;
            r_rect.bottom <= i_area_bottom;
        end
    end

    for (genvar p = 0; p < PANEL_COUNT_P; p++) begin : g_lane
        tdas_clip_lane #(
            .TILE_WIDTH (TILE_WIDTH),
            .TILE_HEIGHT(TILE_HEIGHT)
        ) u_lane (
            .i_rect  (r_rect),
            .i_origin(origin[p]),
            .o_hit   (lane_hit[p]),
            .o_win   (lane_win[p])
        );
    end

    assign hit = panels_ready ? lane_hit : '0;

    tdas_emitter #(
        .PANEL_COUNT_P(PANEL_COUNT_P)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (r_in_vld),
        .o_load_ready (load_ready),
        .i_hit        (hit),
        .i_win        (lane_win),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_panel_index(o_panel_index),
        .o_last       (o_last_window),
        .o_win        (out_win)
    );

    assign o_local_x         = out_win.local_x;
    assign o_local_y         = out_win.local_y;
    assign o_window_width    = out_win.width;
    assign o_window_height   = out_win.height;
    assign o_source_start    = out_win.start;
    assign o_source_stride   = out_win.stride;
    assign o_rows_contiguous = out_win.contig;

    // words of one rectangle leave in rising panel order
    a_panel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_window
        |=> o_out_valid && (o_panel_index > $past(o_panel_index)))
        else $error("window words out of panel order");

    // no new window word appears while panels are not ready and none is pending
    a_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !panels_ready && !o_out_valid |=> !o_out_valid)
        else $error("window word while panels not ready");

    // addressed panel is always one that exists
    a_panel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_panel_index < IDX_W'(PANEL_COUNT_P)))
        else $error("panel index out of range");

endmodule
